// File: rtl/dssm_pkg.sv
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types and constants for the dequantised span SAD and peak block.
// ----------------------------------------------------------------------------
package dssm_pkg;

    localparam int unsigned LUMA_W      = 8;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned GRAY_W      = 8;
    localparam int unsigned DIFF_W      = 8;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned TABLE_WORDS = 4;
    localparam int unsigned TABLE_IDX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned ENTRY_IDX_W = 5;
    localparam int unsigned S_DATA_W    = 16;
    localparam int unsigned M_DATA_W    = 40;

    // Highest level that has its own table entry; larger levels clamp to it.
    localparam logic [ENTRY_IDX_W-1:0] LEVEL_MAX = 5'd31;

    // One classified pixel passed from the front end to the accumulator.
    typedef struct packed {
        logic              last;
        logic [DIFF_W-1:0] diff;
    } dssm_item_t;

    localparam int unsigned ITEM_W = $bits(dssm_item_t);

endpackage

// File: rtl/dssm_front.sv
// ----------------------------------------------------------------------------
// dssm_front
// Holds the gray table, dequantises the stored level and registers the
// absolute difference against the new luma.
// ----------------------------------------------------------------------------
module dssm_front
    import dssm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [TABLE_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [LUMA_W-1:0]      in_luma,
    input  logic [LEVEL_W-1:0]     in_level,
    input  logic                   in_last,
    output logic                   q_valid,
    input  logic                   q_ready,
    output dssm_item_t             q_item
);

    logic [CFG_DATA_W-1:0]  gray_table_reg [TABLE_WORDS];
    logic [ENTRY_IDX_W-1:0] entry_idx;
    logic [CFG_DATA_W-1:0]  table_word;
    logic [GRAY_W-1:0]      gray;
    dssm_item_t             item_next;
    dssm_item_t             stage_reg;
    logic                   stage_valid_reg;

    always_comb begin
        if (in_level > LEVEL_W'(LEVEL_MAX)) begin
            entry_idx = LEVEL_MAX;
        end else begin
            entry_idx = in_level[ENTRY_IDX_W-1:0];
        end
        table_word = gray_table_reg[entry_idx[ENTRY_IDX_W-1:3]];
        gray       = table_word[{entry_idx[2:0], 3'b000} +: GRAY_W];
        item_next.last = in_last;
        if (in_luma > gray) begin
            item_next.diff = in_luma - gray;
        end else begin
            item_next.diff = gray - in_luma;
        end
    end

    assign in_ready = !stage_valid_reg || q_ready;
    assign q_valid  = stage_valid_reg;
    assign q_item   = stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_WORDS; i++) begin
                gray_table_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            gray_table_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            stage_valid_reg <= 1'b1;
        end else if (q_ready) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            stage_reg <= item_next;
        end
    end

endmodule

// File: rtl/dssm_fifo.sv
// ----------------------------------------------------------------------------
// dssm_fifo
// Short register queue that decouples the front end from the accumulator.
// ----------------------------------------------------------------------------
module dssm_fifo
    import dssm_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  dssm_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output dssm_item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    dssm_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

// File: rtl/dssm_back.sv
// ----------------------------------------------------------------------------
// dssm_back
// Accumulates the span sum and peak and holds each finished span result in
// an output register until it is taken.
// ----------------------------------------------------------------------------
module dssm_back
    import dssm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  dssm_item_t          q_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [SUM_W-1:0]    running_sum_reg;
    logic [DIFF_W-1:0]   running_peak_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [DIFF_W-1:0]   peak_next;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                take;

    // A mid-span word never needs the output register, so it is never held.
    assign q_ready  = !q_item.last || !out_valid_reg || m_tready;
    assign take     = q_valid && q_ready;
    assign sum_next = running_sum_reg + SUM_W'(q_item.diff);
    assign peak_next = (q_item.diff > running_peak_reg) ? q_item.diff : running_peak_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg  <= '0;
            running_peak_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (take) begin
                if (q_item.last) begin
                    running_sum_reg  <= '0;
                    running_peak_reg <= '0;
                end else begin
                    running_sum_reg  <= sum_next;
                    running_peak_reg <= peak_next;
                end
            end
            if (take && q_item.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && q_item.last) begin
            out_data_reg <= {peak_next, sum_next};
        end
    end

    a_clear_after_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_item.last) |=> (running_sum_reg == '0 && running_peak_reg == '0))
        else $error("accumulators not cleared after span end");

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_item.last) |=> m_tvalid)
        else $error("span end did not produce a result");

endmodule

// File: rtl/dequantized_span_sad_max.sv
// ----------------------------------------------------------------------------
// dequantized_span_sad_max
// Sum and peak of absolute differences between new luma and dequantised
// stored levels over a span of pixels.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bit first)       Handshake
//  s_        in         tdata: new_luma[7:0], old_level[15:8];  tvalid/tready
//                       tlast: span_end
//  m_        out        tdata: abs_diff_sum[31:0],              tvalid/tready
//                       peak_diff[39:32]
//  cfg_      in         gray_table_word0..3 by cfg_index        cfg_we only
//
// One pixel word is accepted every clock cycle while the front register is
// empty or the queue has room; the table lookup is combinational and the
// accumulator is updated on each accepted word. A result passes through the
// front register, the queue and the output register in turn after its
// span-end word is accepted. Reset is synchronous and active low; it clears
// the gray table, the running sum and peak, the queue and all valid flags.
// A stall on the result side only holds back span-end words; the queue soaks
// up the delay so that the input keeps flowing until it fills.
//
// The front end clamps the level to 31, reads the gray value from the table
// held in four 64-bit registers (level 8w+b in byte b of word w) and
// registers the absolute difference. The back end adds it into a 32-bit sum
// that wraps and keeps the largest difference; on a span-end word it
// latches both, including that word, and clears the accumulators.
// ----------------------------------------------------------------------------
module dequantized_span_sad_max
    import dssm_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration writes.
    input  logic                   cfg_we,
    input  logic [TABLE_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Pixel words.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // new_luma[7:0], old_level[15:8]
    input  logic                   s_tlast,   // span_end
    // Span results.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata    // abs_diff_sum[31:0], peak_diff[39:32]
);

    logic       fq_valid;
    logic       fq_ready;
    dssm_item_t fq_item;
    logic       qb_valid;
    logic       qb_ready;
    dssm_item_t qb_item;

    dssm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_luma   (s_tdata[LUMA_W-1:0]),
        .in_level  (s_tdata[LUMA_W +: LEVEL_W]),
        .in_last   (s_tlast),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    // The queue lets the front end keep taking pixels while a finished result
    // waits on the output side.
    dssm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    dssm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
